FILE: rtl/core/pla_pkg.sv
// Shared constants, types and the arctangent table of the launch angle solver.
package pla_pkg;

  // Field widths
  localparam int COORD_W  = 20;            // target_x, target_y
  localparam int SPEED_W  = 15;            // muzzle_speed
  localparam int ANGLE_W  = 16;            // launch_angle, Q3.13

  // Internal widths
  localparam int SQ_W     = 2 * SPEED_W;   // v^2, unsigned
  localparam int GX_W     = 31;            // g*x and g*y, signed
  localparam int DISC_W   = 64;            // discriminant, signed
  localparam int RAD_W    = 62;            // non-negative discriminant fits here
  localparam int ROOT_W   = RAD_W / 2;     // integer square root
  localparam int CORDIC_W = 44;            // CORDIC x/y datapath, signed
  localparam int NORM_W   = 42;            // magnitude used for normalization
  localparam int ACC_W    = 34;            // angle accumulator, Q30, signed

  // g = 9.8 in input units is 627.2 per LSB: 627 plus a tenth of 2*|x|
  localparam logic [9:0]  G_INT    = 10'd627;
  localparam logic [31:0] RECIP_10 = 32'hCCCCCCCD;   // ceil(2^35 / 10)
  localparam int          RECIP_SH = 35;

  // CORDIC
  localparam int TABLE_LEN        = 24;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam logic signed [ACC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam int ANGLE_LIMIT      = 25736;

  // Data carried alongside the square root
  typedef struct packed {
    logic [SQ_W-1:0]        a;     // v^2
    logic signed [GX_W-1:0] b;     // g*x
    logic                   neg;   // discriminant below zero
  } pla_side_t;

  // One result item
  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      no_solution;
  } pla_result_t;

  // atan(2^-idx) in Q30
  function automatic logic signed [ACC_W-1:0] atan_q30(input int unsigned idx);
    logic signed [ACC_W-1:0] r;
    case (idx)
      0:       r = 34'sd843314857;
      1:       r = 34'sd497837829;
      2:       r = 34'sd263043837;
      3:       r = 34'sd133525159;
      4:       r = 34'sd67021687;
      5:       r = 34'sd33543516;
      6:       r = 34'sd16775851;
      7:       r = 34'sd8388437;
      8:       r = 34'sd4194283;
      9:       r = 34'sd2097149;
      10:      r = 34'sd1048576;
      11:      r = 34'sd524288;
      12:      r = 34'sd262144;
      13:      r = 34'sd131072;
      14:      r = 34'sd65536;
      15:      r = 34'sd32768;
      16:      r = 34'sd16384;
      17:      r = 34'sd8192;
      18:      r = 34'sd4096;
      19:      r = 34'sd2048;
      20:      r = 34'sd1024;
      21:      r = 34'sd512;
      22:      r = 34'sd256;
      23:      r = 34'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/pla_if.sv
// Valid/ready channel interfaces for target items and angle results.
interface pla_target_if import pla_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] target_x;
  logic signed [COORD_W-1:0] target_y;

  modport source(output valid, output target_x, output target_y, input ready);
  modport sink(input valid, input target_x, input target_y, output ready);
endinterface

interface pla_angle_if import pla_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] launch_angle;
  logic                      no_solution;

  modport source(output valid, output launch_angle, output no_solution, input ready);
  modport sink(input valid, input launch_angle, input no_solution, output ready);
endinterface

FILE: rtl/core/pla_isqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband data.
module pla_isqrt import pla_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  in_rad,
  input  pla_side_t         in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output pla_side_t         out_side
);

  localparam int RMW = ROOT_W + 2;   // remainder width

  logic              vld  [ROOT_W];
  logic [RMW-1:0]    rem  [ROOT_W];
  logic [ROOT_W-1:0] root [ROOT_W];
  logic [RAD_W-1:0]  rad  [ROOT_W];
  pla_side_t         side [ROOT_W];

  logic [RMW-1:0]    rem_next  [ROOT_W];
  logic [ROOT_W-1:0] root_next [ROOT_W];

  // Each stage brings down the next bit pair and tries root*4+1
  always_comb begin
    logic [RMW-1:0]    p_rem;
    logic [ROOT_W-1:0] p_root;
    logic [RAD_W-1:0]  p_rad;
    logic [RMW+1:0]    widened;
    logic [RMW+1:0]    trial;
    for (int k = 0; k < ROOT_W; k++) begin
      p_rem   = (k == 0) ? '0 : rem[k-1];
      p_root  = (k == 0) ? '0 : root[k-1];
      p_rad   = (k == 0) ? in_rad : rad[k-1];
      widened = {p_rem, p_rad[2*(ROOT_W-1-k) +: 2]};
      trial   = {2'b00, p_root, 2'b01};
      if (widened >= trial) begin
        rem_next[k]  = RMW'(widened - trial);
        root_next[k] = {p_root[ROOT_W-2:0], 1'b1};
      end else begin
        rem_next[k]  = RMW'(widened);
        root_next[k] = {p_root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ROOT_W; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < ROOT_W; k++) vld[k] <= vld[k-1];
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      rad[0]  <= in_rad;
      side[0] <= in_side;
      for (int k = 1; k < ROOT_W; k++) begin
        rad[k]  <= rad[k-1];
        side[k] <= side[k-1];
      end
      for (int k = 0; k < ROOT_W; k++) begin
        rem[k]  <= rem_next[k];
        root[k] <= root_next[k];
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign out_root  = root[ROOT_W-1];
  assign out_side  = side[ROOT_W-1];

endmodule

FILE: rtl/core/pla_cordic.sv
// Two-lane pipelined vectoring CORDIC: normalize, pre-rotate, iterate, round.
module pla_cordic import pla_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic                      in_neg,
  input  logic signed [GX_W-1:0]    in_x,
  input  logic signed [ROOT_W+1:0]  in_ya,
  input  logic signed [ROOT_W+1:0]  in_yb,
  output logic                      out_valid,
  output logic                      out_neg,
  output logic signed [ANGLE_W-1:0] out_qa,
  output logic signed [ANGLE_W-1:0] out_qb
);

  localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int Q_W   = ACC_W - 17;

  typedef struct packed {
    logic [NORM_W-1:0]          m;
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
  } norm_t;

  // Double by s when the magnitude stays below 2^41
  function automatic norm_t norm_step(input norm_t v, input int unsigned s);
    norm_t r;
    r = v;
    if ((v.m >> (NORM_W - 1 - s)) == '0) begin
      r.m = v.m << s;
      r.x = v.x <<< s;
      r.y = v.y <<< s;
    end
    return r;
  endfunction

  // Stage registers
  logic  n1_v, n2_v, n3_v, p_v, f_v;
  logic  n1_neg, n2_neg, n3_neg, p_neg, f_neg;
  logic  n1_zero [2];
  logic  n2_zero [2];
  logic  n3_zero [2];
  logic  p_zero  [2];
  norm_t n1 [2];
  norm_t n2 [2];
  norm_t n3 [2];
  logic signed [CORDIC_W-1:0] p_x [2];
  logic signed [CORDIC_W-1:0] p_y [2];
  logic signed [ACC_W-1:0]    p_z [2];
  logic signed [ANGLE_W-1:0]  f_q [2];

  logic                       it_v    [STEPS];
  logic                       it_neg  [STEPS];
  logic                       it_zero [STEPS][2];
  logic signed [CORDIC_W-1:0] it_x    [STEPS][2];
  logic signed [CORDIC_W-1:0] it_y    [STEPS][2];
  logic signed [ACC_W-1:0]    it_z    [STEPS][2];

  // Combinational next values
  norm_t                      n1_next [2];
  logic                       zero_next [2];
  norm_t                      n2_next [2];
  norm_t                      n3_next [2];
  logic signed [CORDIC_W-1:0] p_x_next [2];
  logic signed [CORDIC_W-1:0] p_y_next [2];
  logic signed [ACC_W-1:0]    p_z_next [2];
  logic signed [CORDIC_W-1:0] it_x_next [STEPS][2];
  logic signed [CORDIC_W-1:0] it_y_next [STEPS][2];
  logic signed [ACC_W-1:0]    it_z_next [STEPS][2];
  logic signed [ANGLE_W-1:0]  f_q_next [2];

  // Entry: widen, take magnitudes, spot the zero vector
  always_comb begin
    logic signed [CORDIC_W-1:0] xe;
    logic signed [CORDIC_W-1:0] ye;
    logic signed [CORDIC_W-1:0] ax;
    logic signed [CORDIC_W-1:0] ay;
    for (int l = 0; l < 2; l++) begin
      xe = CORDIC_W'(in_x);
      ye = (l == 0) ? CORDIC_W'(in_ya) : CORDIC_W'(in_yb);
      ax = (xe < 0) ? -xe : xe;
      ay = (ye < 0) ? -ye : ye;
      n1_next[l].x = xe;
      n1_next[l].y = ye;
      n1_next[l].m = (ax > ay) ? ax[NORM_W-1:0] : ay[NORM_W-1:0];
      zero_next[l] = (xe == 0) && (ye == 0);
    end
  end

  // Normalization, coarse and fine halves of the shift search
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      n2_next[l] = norm_step(norm_step(norm_step(n1[l], 32), 16), 8);
      n3_next[l] = norm_step(norm_step(norm_step(n2[l], 4), 2), 1);
    end
  end

  // Pre-rotation into the right half plane
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      p_x_next[l] = n3[l].x;
      p_y_next[l] = n3[l].y;
      p_z_next[l] = '0;
      if (n3[l].x < 0) begin
        if (n3[l].y >= 0) begin
          p_x_next[l] = n3[l].y;
          p_y_next[l] = -n3[l].x;
          p_z_next[l] = HALF_PI_Q30;
        end else begin
          p_x_next[l] = -n3[l].y;
          p_y_next[l] = n3[l].x;
          p_z_next[l] = -HALF_PI_Q30;
        end
      end
    end
  end

  // CORDIC iterations, one per stage
  always_comb begin
    logic signed [CORDIC_W-1:0] cx;
    logic signed [CORDIC_W-1:0] cy;
    logic signed [ACC_W-1:0]    cz;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    for (int k = 0; k < STEPS; k++) begin
      for (int l = 0; l < 2; l++) begin
        cx = (k == 0) ? p_x[l] : it_x[k-1][l];
        cy = (k == 0) ? p_y[l] : it_y[k-1][l];
        cz = (k == 0) ? p_z[l] : it_z[k-1][l];
        xs = cx >>> k;
        ys = cy >>> k;
        if (cy > 0) begin
          it_x_next[k][l] = cx + ys;
          it_y_next[k][l] = cy - xs;
          it_z_next[k][l] = cz + atan_q30(k);
        end else begin
          it_x_next[k][l] = cx - ys;
          it_y_next[k][l] = cy + xs;
          it_z_next[k][l] = cz - atan_q30(k);
        end
      end
    end
  end

  // Round Q30 to Q13 and clamp; a zero vector gives a zero angle
  always_comb begin
    logic signed [ACC_W-1:0] zr;
    logic signed [Q_W-1:0]   q;
    for (int l = 0; l < 2; l++) begin
      zr = it_z[STEPS-1][l] + ACC_W'(65536);
      q  = zr[ACC_W-1:17];
      if (it_zero[STEPS-1][l]) begin
        f_q_next[l] = '0;
      end else if (q > Q_W'(ANGLE_LIMIT)) begin
        f_q_next[l] = ANGLE_W'(ANGLE_LIMIT);
      end else if (q < -Q_W'(ANGLE_LIMIT)) begin
        f_q_next[l] = -ANGLE_W'(ANGLE_LIMIT);
      end else begin
        f_q_next[l] = q[ANGLE_W-1:0];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      n1_v <= 1'b0;
      n2_v <= 1'b0;
      n3_v <= 1'b0;
      p_v  <= 1'b0;
      f_v  <= 1'b0;
      for (int k = 0; k < STEPS; k++) it_v[k] <= 1'b0;
    end else if (en) begin
      n1_v    <= in_valid;
      n2_v    <= n1_v;
      n3_v    <= n2_v;
      p_v     <= n3_v;
      it_v[0] <= p_v;
      for (int k = 1; k < STEPS; k++) it_v[k] <= it_v[k-1];
      f_v     <= it_v[STEPS-1];
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      n1_neg    <= in_neg;
      n2_neg    <= n1_neg;
      n3_neg    <= n2_neg;
      p_neg     <= n3_neg;
      it_neg[0] <= p_neg;
      for (int k = 1; k < STEPS; k++) it_neg[k] <= it_neg[k-1];
      f_neg     <= it_neg[STEPS-1];
      for (int l = 0; l < 2; l++) begin
        n1[l]         <= n1_next[l];
        n1_zero[l]    <= zero_next[l];
        n2[l]         <= n2_next[l];
        n2_zero[l]    <= n1_zero[l];
        n3[l]         <= n3_next[l];
        n3_zero[l]    <= n2_zero[l];
        p_x[l]        <= p_x_next[l];
        p_y[l]        <= p_y_next[l];
        p_z[l]        <= p_z_next[l];
        p_zero[l]     <= n3_zero[l];
        it_zero[0][l] <= p_zero[l];
        for (int k = 1; k < STEPS; k++) it_zero[k][l] <= it_zero[k-1][l];
        for (int k = 0; k < STEPS; k++) begin
          it_x[k][l] <= it_x_next[k][l];
          it_y[k][l] <= it_y_next[k][l];
          it_z[k][l] <= it_z_next[k][l];
        end
        f_q[l] <= f_q_next[l];
      end
    end
  end

  assign out_valid = f_v;
  assign out_neg   = f_neg;
  assign out_qa    = f_q[0];
  assign out_qb    = f_q[1];

endmodule

FILE: rtl/core/projectile_launch_angle.sv
// Drag-free launch angle solver: top level with discriminant, root, CORDIC and output stage.
//
// Takes one target offset per cycle while target.ready is high and returns one launch
// angle per target, in order. Registers s1 to s5 form v^2, g*x, g*y and the discriminant,
// the square root registers one root bit per stage, s6 forms v^2 +/- sqrt(D), the
// two-lane CORDIC normalizes, pre-rotates, iterates and rounds, and the output register
// takes the smaller angle. The whole pipeline advances together; a two-entry output
// buffer (output register plus skid) lets target.ready stay high while one result waits,
// and ready drops only when both entries are full. muzzle_speed is a plain register
// written through cfg_we/cfg_wdata.
module projectile_launch_angle import pla_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [SPEED_W-1:0] cfg_wdata,
  pla_target_if.sink         target,
  pla_angle_if.source        result
);

  localparam int T_W    = COORD_W + 1;       // 2*|x| + 5
  localparam int PROD_W = T_W + 32;          // times reciprocal of ten
  localparam int Q_W    = PROD_W - RECIP_SH; // tenth
  localparam int PW     = 2 * GX_W;          // signed products
  localparam int YW     = ROOT_W + 2;        // v^2 +/- root

  logic [SPEED_W-1:0] muzzle_speed;
  logic en;

  // Output buffer
  logic        ov, sv;
  pla_result_t od, sd;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      muzzle_speed <= '0;
    end else if (cfg_we) begin
      muzzle_speed <= cfg_wdata;
    end
  end

  assign en           = !sv;
  assign target.ready = en;

  // Stage 1: capture target, square speed
  logic                      s1_v;
  logic signed [COORD_W-1:0] s1_x, s1_y;
  logic [SQ_W-1:0]           s1_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= target.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x <= target.target_x;
      s1_y <= target.target_y;
      s1_a <= SQ_W'(muzzle_speed) * SQ_W'(muzzle_speed);
    end
  end

  // Stage 2: magnitudes times 627 and the rounded tenth of 2*|x| and 2*|y|
  logic [COORD_W-1:0] x_mag, y_mag;
  logic [T_W-1:0]     x_t, y_t;
  logic [PROD_W-1:0]  x_pr, y_pr;

  assign x_mag = s1_x[COORD_W-1] ? COORD_W'(-s1_x) : COORD_W'(s1_x);
  assign y_mag = s1_y[COORD_W-1] ? COORD_W'(-s1_y) : COORD_W'(s1_y);
  assign x_t   = {x_mag, 1'b0} + T_W'(5);
  assign y_t   = {y_mag, 1'b0} + T_W'(5);
  assign x_pr  = PROD_W'(x_t) * PROD_W'(RECIP_10);
  assign y_pr  = PROD_W'(y_t) * PROD_W'(RECIP_10);

  logic            s2_v, s2_xneg, s2_yneg;
  logic [SQ_W-1:0] s2_a, s2_xlo, s2_ylo;
  logic [Q_W-1:0]  s2_xq, s2_yq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_a    <= s1_a;
      s2_xneg <= s1_x[COORD_W-1];
      s2_yneg <= s1_y[COORD_W-1];
      s2_xlo  <= SQ_W'(x_mag) * SQ_W'(G_INT);
      s2_ylo  <= SQ_W'(y_mag) * SQ_W'(G_INT);
      s2_xq   <= x_pr[PROD_W-1:RECIP_SH];
      s2_yq   <= y_pr[PROD_W-1:RECIP_SH];
    end
  end

  // Stage 3: signed g*x and g*y
  logic [SQ_W-1:0] x_sum, y_sum;

  assign x_sum = s2_xlo + SQ_W'(s2_xq);
  assign y_sum = s2_ylo + SQ_W'(s2_yq);

  logic                   s3_v;
  logic [SQ_W-1:0]        s3_a;
  logic signed [GX_W-1:0] s3_b, s3_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_a <= s2_a;
      s3_b <= s2_xneg ? -$signed(GX_W'(x_sum)) : $signed(GX_W'(x_sum));
      s3_c <= s2_yneg ? -$signed(GX_W'(y_sum)) : $signed(GX_W'(y_sum));
    end
  end

  // Stage 4: the three products of the discriminant
  logic                   s4_v;
  logic [2*SQ_W-1:0]      s4_aa;
  logic signed [PW-1:0]   s4_bb, s4_ac;
  logic [SQ_W-1:0]        s4_a;
  logic signed [GX_W-1:0] s4_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_aa <= (2*SQ_W)'(s3_a) * (2*SQ_W)'(s3_a);
      s4_bb <= PW'(s3_b) * PW'(s3_b);
      s4_ac <= PW'($signed({1'b0, s3_a})) * PW'(s3_c);
      s4_a  <= s3_a;
      s4_b  <= s3_b;
    end
  end

  // Stage 5: D = A^2 - B^2 - 2AC
  logic signed [DISC_W-1:0] disc;

  assign disc = $signed(DISC_W'(s4_aa)) - DISC_W'(s4_bb) - (DISC_W'(s4_ac) <<< 1);

  logic             s5_v;
  logic [RAD_W-1:0] s5_rad;
  pla_side_t        s5_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_rad       <= disc[RAD_W-1:0];
      s5_side.a    <= s4_a;
      s5_side.b    <= s4_b;
      s5_side.neg  <= disc[DISC_W-1];
    end
  end

  // Square root
  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  pla_side_t         sq_side;

  pla_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s5_v),
    .in_rad    (s5_rad),
    .in_side   (s5_side),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Stage 6: the two atan2 numerators
  logic                   s6_v, s6_neg;
  logic signed [GX_W-1:0] s6_x;
  logic signed [YW-1:0]   s6_ya, s6_yb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_neg <= sq_side.neg;
      s6_x   <= sq_side.b;
      s6_ya  <= $signed(YW'(sq_side.a)) + $signed(YW'(sq_root));
      s6_yb  <= $signed(YW'(sq_side.a)) - $signed(YW'(sq_root));
    end
  end

  // Both candidate angles
  logic                      cd_v, cd_neg;
  logic signed [ANGLE_W-1:0] cd_qa, cd_qb;

  pla_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s6_v),
    .in_neg    (s6_neg),
    .in_x      (s6_x),
    .in_ya     (s6_ya),
    .in_yb     (s6_yb),
    .out_valid (cd_v),
    .out_neg   (cd_neg),
    .out_qa    (cd_qa),
    .out_qb    (cd_qb)
  );

  // Pick the lower angle, or flag the unreachable target
  pla_result_t pipe_res;

  always_comb begin
    if (cd_neg) begin
      pipe_res.angle       = '0;
      pipe_res.no_solution = 1'b1;
    end else begin
      pipe_res.angle       = (cd_qa < cd_qb) ? cd_qa : cd_qb;
      pipe_res.no_solution = 1'b0;
    end
  end

  // Output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!ov || result.ready) begin
      if (sv) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end else begin
        ov <= cd_v;
      end
    end else if (cd_v && !sv) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || result.ready) begin
      od <= sv ? sd : pipe_res;
    end
    if (ov && !result.ready && !sv) begin
      sd <= pipe_res;
    end
  end

  assign result.valid        = ov;
  assign result.launch_angle = od.angle;
  assign result.no_solution  = od.no_solution;

  // Skid entry only holds data behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid entry full while output register empty");

  // Skid fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(sv) |-> $past(ov && !result.ready))
    else $error("skid entry filled without an output stall");

  // Unreachable target reports a zero angle
  a_nosol_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.no_solution) |-> (result.launch_angle == '0))
    else $error("no_solution with nonzero angle");

  // Angle stays within the clamp
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (($signed(result.launch_angle) <= ANGLE_LIMIT) &&
                      ($signed(result.launch_angle) >= -ANGLE_LIMIT)))
    else $error("launch angle outside clamp range");

endmodule
